FILE: rtl/core/pua_pkg.sv
// Shared types, constants and tables for the polar unwrap address generator.
package pua_pkg;

    localparam int MAX_ANGLE_STEPS_DEF  = 1024;
    localparam int MAX_RADIUS_STEPS_DEF = 256;
    localparam int MAX_IMAGE_SIZE_DEF   = 1024;

    localparam int ANGLE_W  = 10;
    localparam int RADIUS_W = 8;
    localparam int COORD_W  = 10;
    localparam int CFG_W    = 14;
    localparam int AST_W    = 11;
    localparam int RST_W    = 9;
    localparam int IMG_W    = 11;
    localparam int CMP_W    = 14;
    localparam int IDX_W    = 3;

    localparam int PHASE_W      = 32;
    localparam int CORDIC_ITERS = 16;
    localparam int XY_W         = 34;
    localparam int Z_W          = 33;
    localparam int TRIG_W       = XY_W - 14 + 1;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);

    localparam logic [PHASE_W-1:0] ATAN_LUT [CORDIC_ITERS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21353441,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861
    };

    typedef enum logic [IDX_W-1:0] {
        CFG_INNER_RADIUS = 3'd0,
        CFG_OUTER_RADIUS = 3'd1,
        CFG_CENTER_COL   = 3'd2,
        CFG_CENTER_ROW   = 3'd3,
        CFG_ANGLE_STEPS  = 3'd4,
        CFG_RADIUS_STEPS = 3'd5,
        CFG_IMAGE_WIDTH  = 3'd6,
        CFG_IMAGE_HEIGHT = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [ANGLE_W-1:0]  angle_index;
        logic [RADIUS_W-1:0] radius_index;
    } in_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] src_col;
        logic [COORD_W-1:0] src_row;
        logic               in_image;
    } out_item_t;

endpackage

FILE: rtl/core/pua_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module pua_div #(
    parameter int NUM_W  = 24,
    parameter int DEN_W  = 8,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [SIDE_W-1:0] in_side,
    input  logic [DEN_W-1:0]  den,
    output logic              out_valid,
    output logic [NUM_W-1:0]  out_quo,
    output logic [SIDE_W-1:0] out_side
);

    logic              v_reg    [NUM_W];
    logic [DEN_W-1:0]  rem_reg  [NUM_W];
    logic [NUM_W-1:0]  nq_reg   [NUM_W];
    logic [SIDE_W-1:0] side_reg [NUM_W];

    for (genvar i = 0; i < NUM_W; i++) begin : g_stage
        logic              v_prev;
        logic [DEN_W-1:0]  rem_prev;
        logic [NUM_W-1:0]  nq_prev;
        logic [SIDE_W-1:0] side_prev;
        logic [DEN_W:0]    trial;
        logic              ge;
        logic [DEN_W-1:0]  rem_next;
        logic [NUM_W-1:0]  nq_next;

        if (i == 0) begin : g_first
            assign v_prev    = in_valid;
            assign rem_prev  = '0;
            assign nq_prev   = in_num;
            assign side_prev = in_side;
        end
        else begin : g_rest
            assign v_prev    = v_reg[i-1];
            assign rem_prev  = rem_reg[i-1];
            assign nq_prev   = nq_reg[i-1];
            assign side_prev = side_reg[i-1];
        end

        assign trial    = {rem_prev, nq_prev[NUM_W-1]};
        assign ge       = trial >= {1'b0, den};
        assign rem_next = ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
        assign nq_next  = {nq_prev[NUM_W-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                nq_reg[i]   <= nq_next;
                side_reg[i] <= side_prev;
            end
        end
    end

    assign out_valid = v_reg[NUM_W-1];
    assign out_quo   = nq_reg[NUM_W-1];
    assign out_side  = side_reg[NUM_W-1];

endmodule

FILE: rtl/core/pua_cordic.sv
// Pipelined rotation-mode CORDIC, one iteration per stage, with half-turn fold.
module pua_cordic #(
    parameter int SIDE_W = 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [pua_pkg::PHASE_W-1:0]         phase,
    input  logic [SIDE_W-1:0]                   in_side,
    output logic                                out_valid,
    output logic signed [pua_pkg::XY_W-1:0]     out_x,
    output logic signed [pua_pkg::XY_W-1:0]     out_y,
    output logic                                out_flip,
    output logic [SIDE_W-1:0]                   out_side
);

    localparam int N = pua_pkg::CORDIC_ITERS;

    logic                              v_reg    [N];
    logic signed [pua_pkg::XY_W-1:0]   x_reg    [N];
    logic signed [pua_pkg::XY_W-1:0]   y_reg    [N];
    logic signed [pua_pkg::Z_W-1:0]    z_reg    [N];
    logic                              flip_reg [N];
    logic [SIDE_W-1:0]                 side_reg [N];

    logic [pua_pkg::PHASE_W-1:0] quarter;
    logic                        flip0;
    logic [pua_pkg::PHASE_W-1:0] ph0;
    logic signed [pua_pkg::Z_W-1:0] z0;

    assign quarter = phase + 32'h4000_0000;
    assign flip0   = quarter[pua_pkg::PHASE_W-1];
    assign ph0     = flip0 ? (phase ^ 32'h8000_0000) : phase;
    assign z0      = $signed({ph0[pua_pkg::PHASE_W-1], ph0});

    for (genvar i = 0; i < N; i++) begin : g_iter
        logic                             v_prev;
        logic signed [pua_pkg::XY_W-1:0]  x_prev;
        logic signed [pua_pkg::XY_W-1:0]  y_prev;
        logic signed [pua_pkg::Z_W-1:0]   z_prev;
        logic                             flip_prev;
        logic [SIDE_W-1:0]                side_prev;
        logic signed [pua_pkg::XY_W-1:0]  xs;
        logic signed [pua_pkg::XY_W-1:0]  ys;
        logic signed [pua_pkg::Z_W-1:0]   at;
        logic signed [pua_pkg::XY_W-1:0]  x_next;
        logic signed [pua_pkg::XY_W-1:0]  y_next;
        logic signed [pua_pkg::Z_W-1:0]   z_next;

        if (i == 0) begin : g_first
            assign v_prev    = in_valid;
            assign x_prev    = pua_pkg::CORDIC_GAIN;
            assign y_prev    = '0;
            assign z_prev    = z0;
            assign flip_prev = flip0;
            assign side_prev = in_side;
        end
        else begin : g_rest
            assign v_prev    = v_reg[i-1];
            assign x_prev    = x_reg[i-1];
            assign y_prev    = y_reg[i-1];
            assign z_prev    = z_reg[i-1];
            assign flip_prev = flip_reg[i-1];
            assign side_prev = side_reg[i-1];
        end

        assign xs = x_prev >>> i;
        assign ys = y_prev >>> i;
        assign at = $signed({1'b0, pua_pkg::ATAN_LUT[i]});

        always_comb
        begin
            if (!z_prev[pua_pkg::Z_W-1])
            begin
                x_next = x_prev - ys;
                y_next = y_prev + xs;
                z_next = z_prev - at;
            end
            else
            begin
                x_next = x_prev + ys;
                y_next = y_prev - xs;
                z_next = z_prev + at;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i]    <= x_next;
                y_reg[i]    <= y_next;
                z_reg[i]    <= z_next;
                flip_reg[i] <= flip_prev;
                side_reg[i] <= side_prev;
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_x     = x_reg[N-1];
    assign out_y     = y_reg[N-1];
    assign out_flip  = flip_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

FILE: rtl/core/pua_map.sv
// Rounds sin/cos, scales by radius, adds center, rounds and bounds-checks.
module pua_map #(
    parameter int R_W   = 25,
    parameter int LIM_W = 11
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic signed [pua_pkg::XY_W-1:0]  in_x,
    input  logic signed [pua_pkg::XY_W-1:0]  in_y,
    input  logic                             in_flip,
    input  logic signed [R_W-1:0]            in_r,
    input  logic [pua_pkg::CFG_W-1:0]        center_col,
    input  logic [pua_pkg::CFG_W-1:0]        center_row,
    input  logic [LIM_W-1:0]                 w_lim,
    input  logic [LIM_W-1:0]                 h_lim,
    output logic                             out_valid,
    output pua_pkg::out_item_t               out_item
);

    localparam int XY_W   = pua_pkg::XY_W;
    localparam int TRIG_W = pua_pkg::TRIG_W;
    localparam int PROD_W = R_W + TRIG_W;
    localparam int SUMC_W = PROD_W + 2;
    localparam int COL_W  = SUMC_W - 20 + 1;

    // stage A: orient and round to Q.16
    logic signed [XY_W-1:0] xo;
    logic signed [XY_W-1:0] yo;
    logic [XY_W-1:0]        xm;
    logic [XY_W-1:0]        ym;
    logic [XY_W-1:0]        xr;
    logic [XY_W-1:0]        yr;
    logic signed [TRIG_W-1:0] s16_next;
    logic signed [TRIG_W-1:0] c16_next;

    logic                     a_v_reg;
    logic signed [TRIG_W-1:0] a_s16_reg;
    logic signed [TRIG_W-1:0] a_c16_reg;
    logic signed [R_W-1:0]    a_r_reg;

    assign xo = in_flip ? -in_x : in_x;
    assign yo = in_flip ? -in_y : in_y;
    assign xm = xo[XY_W-1] ? XY_W'(-xo) : XY_W'(xo);
    assign ym = yo[XY_W-1] ? XY_W'(-yo) : XY_W'(yo);
    assign xr = (xm + XY_W'(8192)) >> 14;
    assign yr = (ym + XY_W'(8192)) >> 14;
    assign c16_next = xo[XY_W-1] ? -$signed(TRIG_W'(xr)) : $signed(TRIG_W'(xr));
    assign s16_next = yo[XY_W-1] ? -$signed(TRIG_W'(yr)) : $signed(TRIG_W'(yr));

    // stage B: products
    logic                     b_v_reg;
    logic signed [PROD_W-1:0] b_ps_reg;
    logic signed [PROD_W-1:0] b_pc_reg;
    logic signed [PROD_W-1:0] ps_next;
    logic signed [PROD_W-1:0] pc_next;

    assign ps_next = PROD_W'(a_r_reg) * PROD_W'(a_s16_reg);
    assign pc_next = PROD_W'(a_r_reg) * PROD_W'(a_c16_reg);

    // stage C: add center, round to pixels
    logic signed [SUMC_W-1:0] sum_c;
    logic signed [SUMC_W-1:0] sum_r;
    logic [SUMC_W-1:0]        mag_c;
    logic [SUMC_W-1:0]        mag_r;
    logic [SUMC_W-1:0]        rnd_c;
    logic [SUMC_W-1:0]        rnd_r;
    logic signed [COL_W-1:0]  col_next;
    logic signed [COL_W-1:0]  row_next;

    logic                     c_v_reg;
    logic signed [COL_W-1:0]  c_col_reg;
    logic signed [COL_W-1:0]  c_row_reg;

    assign sum_c = SUMC_W'(b_ps_reg) + $signed(SUMC_W'({center_col, 16'b0}));
    assign sum_r = SUMC_W'(b_pc_reg) + $signed(SUMC_W'({center_row, 16'b0}));
    assign mag_c = sum_c[SUMC_W-1] ? SUMC_W'(-sum_c) : SUMC_W'(sum_c);
    assign mag_r = sum_r[SUMC_W-1] ? SUMC_W'(-sum_r) : SUMC_W'(sum_r);
    assign rnd_c = (mag_c + SUMC_W'(20'h80000)) >> 20;
    assign rnd_r = (mag_r + SUMC_W'(20'h80000)) >> 20;
    assign col_next = sum_c[SUMC_W-1] ? -$signed(COL_W'(rnd_c)) : $signed(COL_W'(rnd_c));
    assign row_next = sum_r[SUMC_W-1] ? -$signed(COL_W'(rnd_r)) : $signed(COL_W'(rnd_r));

    // stage D: bounds and output register
    logic               in_bounds;
    pua_pkg::out_item_t item_next;
    logic               d_v_reg;
    pua_pkg::out_item_t d_item_reg;

    assign in_bounds = (c_col_reg > 0) && (c_row_reg > 0)
                    && (c_col_reg < $signed(COL_W'(w_lim)))
                    && (c_row_reg < $signed(COL_W'(h_lim)));

    always_comb
    begin
        item_next.src_col  = in_bounds ? c_col_reg[pua_pkg::COORD_W-1:0] : '0;
        item_next.src_row  = in_bounds ? c_row_reg[pua_pkg::COORD_W-1:0] : '0;
        item_next.in_image = in_bounds;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg <= in_valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_s16_reg  <= s16_next;
            a_c16_reg  <= c16_next;
            a_r_reg    <= in_r;
            b_ps_reg   <= ps_next;
            b_pc_reg   <= pc_next;
            c_col_reg  <= col_next;
            c_row_reg  <= row_next;
            d_item_reg <= item_next;
        end
    end

    assign out_valid = d_v_reg;
    assign out_item  = d_item_reg;

endmodule

FILE: rtl/core/polar_unwrap_address_gen_core.sv
// Top level: polar unwrap (rubber-sheet) source address generator.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------
//  in       | in_valid / in_ready  | in_item (angle_index, radius_index)
//  out      | out_valid / out_ready| out_item (src_col, src_row, in_image)
//  cfg      | cfg_wen              | cfg_idx, cfg_wdata
//
// One transfer per cycle sustained while out_ready stays high. Items pass an input
// register stage, the radius divider (depth 24 at default sizes), the phase divider
// (depth 43), the CORDIC and the map stages. Each divider resolves one quotient bit
// per stage, the CORDIC one iteration per stage. Reset clears only valid bits and registers.
// The whole pipe holds while a result waits and out_ready is low.
module polar_unwrap_address_gen_core #(
    parameter int MAX_ANGLE_STEPS  = pua_pkg::MAX_ANGLE_STEPS_DEF,
    parameter int MAX_RADIUS_STEPS = pua_pkg::MAX_RADIUS_STEPS_DEF,
    parameter int MAX_IMAGE_SIZE   = pua_pkg::MAX_IMAGE_SIZE_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  pua_pkg::in_item_t           in_item,
    output logic                        out_valid,
    input  logic                        out_ready,
    output pua_pkg::out_item_t          out_item,
    input  logic                        cfg_wen,
    input  logic [pua_pkg::IDX_W-1:0]   cfg_idx,
    input  logic [pua_pkg::CFG_W-1:0]   cfg_wdata
);

    localparam int CFG_W   = pua_pkg::CFG_W;
    localparam int CMP_W   = pua_pkg::CMP_W;
    localparam int ANGLE_W = pua_pkg::ANGLE_W;
    localparam int MDW     = $clog2(MAX_ANGLE_STEPS);
    localparam int NDW     = $clog2(MAX_RADIUS_STEPS);
    localparam int LIM_W   = $clog2(MAX_IMAGE_SIZE) + 1;
    localparam int SUM_W   = ((NDW > pua_pkg::RADIUS_W) ? NDW : pua_pkg::RADIUS_W) + CFG_W + 2;
    localparam int R_W     = SUM_W + 1;
    localparam int P2_W    = CFG_W + 1 + pua_pkg::RADIUS_W + 1;
    localparam int PNW     = ANGLE_W + pua_pkg::PHASE_W + 1;

    logic [CFG_W-1:0]          inner_radius_reg;
    logic [CFG_W-1:0]          outer_radius_reg;
    logic [CFG_W-1:0]          center_col_reg;
    logic [CFG_W-1:0]          center_row_reg;
    logic [pua_pkg::AST_W-1:0] angle_steps_reg;
    logic [pua_pkg::RST_W-1:0] radius_steps_reg;
    logic [pua_pkg::IMG_W-1:0] image_width_reg;
    logic [pua_pkg::IMG_W-1:0] image_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_radius_reg <= '0;
            outer_radius_reg <= CFG_W'(16);
            center_col_reg   <= '0;
            center_row_reg   <= '0;
            angle_steps_reg  <= pua_pkg::AST_W'(2);
            radius_steps_reg <= pua_pkg::RST_W'(2);
            image_width_reg  <= pua_pkg::IMG_W'(1024);
            image_height_reg <= pua_pkg::IMG_W'(1024);
        end
        else if (cfg_wen)
        begin
            unique case (pua_pkg::cfg_idx_t'(cfg_idx))
                pua_pkg::CFG_INNER_RADIUS: inner_radius_reg <= cfg_wdata;
                pua_pkg::CFG_OUTER_RADIUS: outer_radius_reg <= cfg_wdata;
                pua_pkg::CFG_CENTER_COL:   center_col_reg   <= cfg_wdata;
                pua_pkg::CFG_CENTER_ROW:   center_row_reg   <= cfg_wdata;
                pua_pkg::CFG_ANGLE_STEPS:  angle_steps_reg  <= cfg_wdata[pua_pkg::AST_W-1:0];
                pua_pkg::CFG_RADIUS_STEPS: radius_steps_reg <= cfg_wdata[pua_pkg::RST_W-1:0];
                pua_pkg::CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata[pua_pkg::IMG_W-1:0];
                pua_pkg::CFG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata[pua_pkg::IMG_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped step counts and image bounds
    logic [CMP_W-1:0] as_x, as_c, rs_x, rs_c, iw_x, ih_x;
    logic [MDW-1:0]   md;
    logic [NDW-1:0]   nd;
    logic [LIM_W-1:0] w_lim, h_lim;

    assign as_x = CMP_W'(angle_steps_reg);
    assign rs_x = CMP_W'(radius_steps_reg);
    assign iw_x = CMP_W'(image_width_reg);
    assign ih_x = CMP_W'(image_height_reg);
    assign as_c = (as_x < CMP_W'(2)) ? CMP_W'(2)
                : (as_x > CMP_W'(MAX_ANGLE_STEPS)) ? CMP_W'(MAX_ANGLE_STEPS) : as_x;
    assign rs_c = (rs_x < CMP_W'(2)) ? CMP_W'(2)
                : (rs_x > CMP_W'(MAX_RADIUS_STEPS)) ? CMP_W'(MAX_RADIUS_STEPS) : rs_x;
    assign md = MDW'(as_c - CMP_W'(1));
    assign nd = NDW'(rs_c - CMP_W'(1));
    assign w_lim = (iw_x > CMP_W'(MAX_IMAGE_SIZE)) ? LIM_W'(MAX_IMAGE_SIZE) : LIM_W'(iw_x);
    assign h_lim = (ih_x > CMP_W'(MAX_IMAGE_SIZE)) ? LIM_W'(MAX_IMAGE_SIZE) : LIM_W'(ih_x);

    logic en;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // stage 0: radius products
    logic                   s0_v_reg;
    logic [ANGLE_W-1:0]     s0_a_reg;
    logic [CFG_W+NDW-1:0]   s0_p1_reg;
    logic signed [P2_W-1:0] s0_p2_reg;
    logic signed [CFG_W:0]  diff;
    logic signed [P2_W-1:0] p2_next;

    assign diff    = $signed({1'b0, outer_radius_reg}) - $signed({1'b0, inner_radius_reg});
    assign p2_next = P2_W'(diff) * $signed(P2_W'(in_item.radius_index));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_a_reg  <= in_item.angle_index;
            s0_p1_reg <= (CFG_W+NDW)'(inner_radius_reg) * (CFG_W+NDW)'(nd);
            s0_p2_reg <= p2_next;
        end
    end

    // radius divide
    logic signed [SUM_W-1:0] rsum;
    logic [SUM_W-1:0]        rmag;
    logic [SUM_W-1:0]        rnum;
    logic                    rd_v;
    logic [SUM_W-1:0]        rd_q;
    logic [ANGLE_W:0]        rd_side;

    assign rsum = $signed(SUM_W'(s0_p1_reg)) + SUM_W'(s0_p2_reg);
    assign rmag = rsum[SUM_W-1] ? SUM_W'(-rsum) : SUM_W'(rsum);
    assign rnum = rmag + SUM_W'(nd >> 1);

    pua_div #(.NUM_W(SUM_W), .DEN_W(NDW), .SIDE_W(ANGLE_W + 1)) u_rdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s0_v_reg),
        .in_num    (rnum),
        .in_side   ({rsum[SUM_W-1], s0_a_reg}),
        .den       (nd),
        .out_valid (rd_v),
        .out_quo   (rd_q),
        .out_side  (rd_side)
    );

    // phase divide
    logic signed [R_W-1:0]      r16;
    logic [PNW-1:0]             pnum;
    logic                       pd_v;
    logic [PNW-1:0]             pd_q;
    logic [R_W-1:0]             pd_side;
    logic [pua_pkg::PHASE_W-1:0] phase;

    assign r16  = rd_side[ANGLE_W] ? -$signed(R_W'(rd_q)) : $signed(R_W'(rd_q));
    assign pnum = PNW'({rd_side[ANGLE_W-1:0], 32'b0}) + PNW'(md >> 1);

    pua_div #(.NUM_W(PNW), .DEN_W(MDW), .SIDE_W(R_W)) u_pdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rd_v),
        .in_num    (pnum),
        .in_side   (r16),
        .den       (md),
        .out_valid (pd_v),
        .out_quo   (pd_q),
        .out_side  (pd_side)
    );

    assign phase = pd_q[pua_pkg::PHASE_W-1:0] ^ 32'h8000_0000;

    logic                              cd_v;
    logic signed [pua_pkg::XY_W-1:0]   cd_x;
    logic signed [pua_pkg::XY_W-1:0]   cd_y;
    logic                              cd_flip;
    logic [R_W-1:0]                    cd_side;

    pua_cordic #(.SIDE_W(R_W)) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pd_v),
        .phase     (phase),
        .in_side   (pd_side),
        .out_valid (cd_v),
        .out_x     (cd_x),
        .out_y     (cd_y),
        .out_flip  (cd_flip),
        .out_side  (cd_side)
    );

    pua_map #(.R_W(R_W), .LIM_W(LIM_W)) u_map (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (cd_v),
        .in_x       (cd_x),
        .in_y       (cd_y),
        .in_flip    (cd_flip),
        .in_r       ($signed(cd_side)),
        .center_col (center_col_reg),
        .center_row (center_row_reg),
        .w_lim      (w_lim),
        .h_lim      (h_lim),
        .out_valid  (out_valid),
        .out_item   (out_item)
    );

`ifndef ASSERT_OFF
    a_zero_when_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.in_image |-> out_item.src_col == '0 && out_item.src_row == '0)
        else $error("invalid point with nonzero coordinates");

    a_nonzero_when_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.in_image |-> out_item.src_col != '0 && out_item.src_row != '0)
        else $error("valid point on image border zero");

    a_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.in_image
        |-> LIM_W'(out_item.src_col) < w_lim && LIM_W'(out_item.src_row) < h_lim)
        else $error("valid point outside image bounds");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(s0_v_reg) && $stable(rd_v) && $stable(pd_v) && $stable(cd_v))
        else $error("pipeline moved during stall");
`endif

endmodule

FILE: dv/tb_polar_unwrap_address_gen_core.sv
// Testbench for the polar unwrap address generator: scoreboard with bit-exact prediction.
`timescale 1ns / 100ps

class unwrap_scoreboard;
    int unsigned          rp, rs, ccol, crow, asteps, rsteps, img_w, img_h;
    pua_pkg::out_item_t   addr_q[$];
    int unsigned          n_fail;
    int unsigned          n_checked;
    int unsigned          n_valid;

    function void reset_regs();
        rp = 0;
        rs = 16;
        ccol = 0;
        crow = 0;
        asteps = 2;
        rsteps = 2;
        img_w = 1024;
        img_h = 1024;
    endfunction

    function void write_reg(pua_pkg::cfg_idx_t idx, int unsigned val);
        case (idx)
            pua_pkg::CFG_INNER_RADIUS: rp = val & 14'h3fff;
            pua_pkg::CFG_OUTER_RADIUS: rs = val & 14'h3fff;
            pua_pkg::CFG_CENTER_COL:   ccol = val & 14'h3fff;
            pua_pkg::CFG_CENTER_ROW:   crow = val & 14'h3fff;
            pua_pkg::CFG_ANGLE_STEPS:  asteps = val & 11'h7ff;
            pua_pkg::CFG_RADIUS_STEPS: rsteps = val & 9'h1ff;
            pua_pkg::CFG_IMAGE_WIDTH:  img_w = val & 11'h7ff;
            pua_pkg::CFG_IMAGE_HEIGHT: img_h = val & 11'h7ff;
            default: ;
        endcase
    endfunction

    function longint rdiv(longint n, longint d);
        if (n >= 0)
            return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    function pua_pkg::out_item_t map_point(pua_pkg::in_item_t it);
        longint               md, nd, w, h, q, x, y, z, xs, ys, s16, c16, r16, col, row;
        logic [31:0]          ph;
        bit                   flip;
        pua_pkg::out_item_t   o;
        md = (asteps < 2) ? 1 : (asteps > 1024) ? 1023 : asteps - 1;
        nd = (rsteps < 2) ? 1 : (rsteps > 256) ? 255 : rsteps - 1;
        w = (img_w > 1024) ? 1024 : img_w;
        h = (img_h > 1024) ? 1024 : img_h;
        q = ((longint'(it.angle_index) << 32) + md / 2) / md;
        ph = q[31:0] + 32'h8000_0000;
        flip = 0;
        if (((ph + 32'h4000_0000) & 32'h8000_0000) != 0) begin
            ph = ph + 32'h8000_0000;
            flip = 1;
        end
        z = longint'($signed(ph));
        x = 652032874;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys;
                y += xs;
                z -= pua_pkg::ATAN_LUT[i];
            end else begin
                x += ys;
                y -= xs;
                z += pua_pkg::ATAN_LUT[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        s16 = rdiv(y, 16384);
        c16 = rdiv(x, 16384);
        r16 = rdiv(longint'(rp) * nd + (longint'(rs) - longint'(rp)) * it.radius_index, nd);
        col = rdiv(r16 * s16 + longint'(ccol) * 65536, 1048576);
        row = rdiv(r16 * c16 + longint'(crow) * 65536, 1048576);
        o = '0;
        if (col > 0 && row > 0 && col < w && row < h) begin
            o.src_col = col[9:0];
            o.src_row = row[9:0];
            o.in_image = 1'b1;
        end
        return o;
    endfunction

    function void note_input(pua_pkg::in_item_t it);
        addr_q.push_back(map_point(it));
    endfunction

    function void check_result(pua_pkg::out_item_t got);
        pua_pkg::out_item_t exp_o;
        n_checked++;
        if (got.in_image)
            n_valid++;
        if (addr_q.size() == 0) begin
            n_fail++;
            if (n_fail <= 10)
                $display("unexpected transfer: %p", got);
            return;
        end
        exp_o = addr_q.pop_front();
        if (got.src_col !== exp_o.src_col || got.src_row !== exp_o.src_row
                || got.in_image !== exp_o.in_image) begin
            n_fail++;
            if (n_fail <= 10)
                $display("mismatch: exp col %0d row %0d ok %0b, got col %0d row %0d ok %0b",
                         exp_o.src_col, exp_o.src_row, exp_o.in_image,
                         got.src_col, got.src_row, got.in_image);
        end
    endfunction
endclass

module tb_polar_unwrap_address_gen_core;
    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    pua_pkg::in_item_t             in_item;
    logic                          out_valid;
    logic                          out_ready;
    pua_pkg::out_item_t            out_item;
    logic                          cfg_wen;
    logic [pua_pkg::IDX_W-1:0]     cfg_idx;
    logic [pua_pkg::CFG_W-1:0]     cfg_wdata;

    unwrap_scoreboard     sb;
    int                   send_idle_pct;
    int                   recv_idle_pct;
    int unsigned          n_sent;

    polar_unwrap_address_gen_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_wen   (cfg_wen),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    initial clk = 0;
    always #10 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready)
                sb.check_result(out_item);
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_cfg(pua_pkg::cfg_idx_t idx, int unsigned val);
        cfg_wen <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= val[pua_pkg::CFG_W-1:0];
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.addr_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic send_point(int unsigned a, int unsigned k);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item.angle_index <= a[pua_pkg::ANGLE_W-1:0];
        in_item.radius_index <= k[pua_pkg::RADIUS_W-1:0];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_input(in_item);
        n_sent++;
    endtask

    // geometry: rp, rs, ccol, crow, M, N, W, H
    task automatic set_geometry(int unsigned g[8]);
        drain();
        for (int i = 0; i < 8; i++)
            write_cfg(pua_pkg::cfg_idx_t'(i), g[i]);
        cfg_wen <= 1'b0;
    endtask

    task automatic random_geometry();
        int unsigned g[8];
        g[0] = $urandom_range(1600);
        g[1] = $urandom_range(100) < 10 ? $urandom_range(16383) : $urandom_range(4000);
        g[2] = $urandom_range(100) < 10 ? $urandom_range(16383) : $urandom_range(3000, 9000);
        g[3] = $urandom_range(100) < 10 ? $urandom_range(16383) : $urandom_range(3000, 9000);
        g[4] = $urandom_range(100) < 10 ? $urandom_range(2047) : $urandom_range(2, 1024);
        g[5] = $urandom_range(100) < 10 ? $urandom_range(511) : $urandom_range(2, 256);
        g[6] = $urandom_range(100) < 10 ? $urandom_range(2047) : $urandom_range(1, 1024);
        g[7] = $urandom_range(100) < 10 ? $urandom_range(2047) : $urandom_range(1, 1024);
        set_geometry(g);
    endtask

    task automatic random_points(int cnt);
        int unsigned m, n;
        m = (sb.asteps < 2) ? 2 : (sb.asteps > 1024) ? 1024 : sb.asteps;
        n = (sb.rsteps < 2) ? 2 : (sb.rsteps > 256) ? 256 : sb.rsteps;
        for (int i = 0; i < cnt; i++) begin
            if ($urandom_range(99) < 85)
                send_point($urandom_range(m - 1), $urandom_range(n - 1));
            else
                send_point($urandom_range(1023), $urandom_range(255));
        end
    endtask

    initial begin
        sb = new();
        sb.reset_regs();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_ready = 1'b0;
        cfg_wen = 1'b0;
        cfg_idx = '0;
        cfg_wdata = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        n_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values, then directed geometries including extremes
        send_point(0, 0);
        send_point(1, 1);
        set_geometry('{160, 1600, 8192, 8192, 1024, 256, 1024, 1024});
        for (int i = 0; i < 8; i++)
            send_point(i * 146, i * 36);
        send_point(1023, 255);
        send_point(512, 0);
        set_geometry('{16383, 0, 16383, 16383, 2047, 511, 2047, 2047});
        send_point(1023, 255);
        send_point(0, 0);
        send_point(700, 100);
        set_geometry('{0, 16383, 0, 0, 0, 0, 0, 0});
        send_point(1023, 255);
        send_point(0, 128);
        set_geometry('{4000, 100, 8000, 8000, 17, 3, 1000, 900});
        send_point(16, 2);
        send_point(300, 200);
        send_point(8, 1);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 84 : 0;
            recv_idle_pct = (ph == 0) ? 84 : (ph == 1) ? 27 : 0;
            for (int b = 0; b < 4; b++) begin
                random_geometry();
                random_points(100);
            end
        end
        drain();
        $display("Sent %0d points over many geometries, including extreme register values;",
                 n_sent);
        $display("%0d results checked, %0d inside the image.", sb.n_checked, sb.n_valid);
        if (sb.n_fail == 0 && sb.addr_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

FILE: polar_unwrap_address_gen_core.f
rtl/core/pua_pkg.sv
rtl/core/pua_div.sv
rtl/core/pua_cordic.sv
rtl/core/pua_map.sv
rtl/core/polar_unwrap_address_gen_core.sv
dv/tb_polar_unwrap_address_gen_core.sv
